>>> rtl/core/worst_fit_block_allocator_core_macros.svh
// Assertion macros for the worst-fit block allocator core.
// Defining NO_ASSERTIONS turns every macro into an empty body.
`ifndef WORST_FIT_BLOCK_ALLOCATOR_CORE_MACROS_SVH
`define WORST_FIT_BLOCK_ALLOCATOR_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define WFBA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define WFBA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define WFBA_ASSERT_IMP(lbl, ante, cons, msg)
`define WFBA_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

>>> rtl/core/wfba_pkg.sv
// Shared types and constants of the worst-fit block allocator core.
// Used by wfba_scan and worst_fit_block_allocator_core; depends on nothing.
package wfba_pkg;

  localparam int BLOCKS       = 64;
  localparam int SIZE_BITS    = 16;
  localparam int IDX_W        = $clog2(BLOCKS);
  localparam int CNT_W        = IDX_W + 1;
  localparam int CFG_W        = 7;
  localparam int BLK_FIELD_W  = 6;
  localparam int JOB_W        = 10;
  localparam int TOTAL_W      = 24;
  localparam int CfgReset     = 64;

  typedef enum logic {
    FUNC_LOAD  = 1'b0,
    FUNC_ALLOC = 1'b1
  } wfba_func_e;

  typedef struct packed {
    wfba_func_e                 func;
    logic [BLK_FIELD_W-1:0]     block_index;
    logic [SIZE_BITS-1:0]       size_value;
  } wfba_in_t;

  typedef struct packed {
    logic                       granted;
    logic [BLK_FIELD_W-1:0]     chosen_block;
    logic [SIZE_BITS-1:0]       leftover;
    logic [JOB_W-1:0]           job_id;
    logic [TOTAL_W-1:0]         total_used;
  } wfba_out_t;

  typedef struct packed {
    logic                       vld;
    logic                       busy;
    logic [IDX_W-1:0]           idx;
    logic [SIZE_BITS-1:0]       size;
  } wfba_cmp_t;

endpackage

>>> rtl/core/wfba_scan.sv
// Shared compare unit that tracks the largest fitting free block during a scan.
// Depends on wfba_pkg and the core assertion macros.
`include "worst_fit_block_allocator_core_macros.svh"
module wfba_scan (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          clr_i,
  input  logic [wfba_pkg::SIZE_BITS-1:0] req_size_i,
  input  wfba_pkg::wfba_cmp_t           cmp_i,
  output logic                          found_o,
  output logic [wfba_pkg::SIZE_BITS-1:0] best_size_o,
  output logic [wfba_pkg::IDX_W-1:0]    best_idx_o
);
  import wfba_pkg::*;

  logic                 found_q, found_d;
  logic [SIZE_BITS-1:0] best_q, best_d;
  logic [IDX_W-1:0]     best_idx_q, best_idx_d;
  logic                 take;

  assign take = cmp_i.vld && !cmp_i.busy && (cmp_i.size >= req_size_i) &&
                (!found_q || (cmp_i.size > best_q));

  always_comb begin
    found_d    = found_q;
    best_d     = best_q;
    best_idx_d = best_idx_q;
    if (clr_i) begin
      found_d = 1'b0;
    end else if (take) begin
      found_d    = 1'b1;
      best_d     = cmp_i.size;
      best_idx_d = cmp_i.idx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else begin
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q     <= best_d;
    best_idx_q <= best_idx_d;
  end

  assign found_o     = found_q;
  assign best_size_o = best_q;
  assign best_idx_o  = best_idx_q;

  `WFBA_ASSERT_IMP(a_best_fits, found_q && !clr_i, best_q >= req_size_i, "best block too small")
  `WFBA_ASSERT_NXT(a_clr_drops, clr_i, !found_q, "clear did not drop the candidate")
  `WFBA_ASSERT_NXT(a_take_sets, take && !clr_i, found_q && (best_idx_q == $past(cmp_i.idx)), "candidate not taken")

endmodule

>>> rtl/core/worst_fit_block_allocator_core.sv
// Worst-fit block allocator top level: size memory, busy flags, sequencer.
// Depends on wfba_pkg, wfba_scan and the core assertion macros.
//
// A word is taken when start is high and busy is low. A load word writes the
// block size, frees the block and returns its result in the next cycle
// without raising busy. A request word reads one block size per cycle from the
// size memory into a single shared comparator, so it keeps busy high while it
// scans the first blocks_in_use blocks (capped at 64; none when blocks_in_use
// is zero), and its result appears in the first cycle with busy low again.
// Every result sits on out_word_o for exactly one cycle with out_valid_o high;
// the receiver cannot stall it and must take it then. The configuration
// register may only be written while busy is low and no result is pending.
`include "worst_fit_block_allocator_core_macros.svh"
module worst_fit_block_allocator_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  wfba_pkg::wfba_in_t            in_word_i,
  output logic                          out_valid_o,
  output wfba_pkg::wfba_out_t           out_word_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [wfba_pkg::CFG_W-1:0]    cfg_data_i
);
  import wfba_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_DRAIN  = 4'b0100,
    S_FINISH = 4'b1000
  } state_e;

  state_e               state_q, state_d;
  logic [CFG_W-1:0]     cfg_q;
  logic [CNT_W-1:0]     limit_q, limit_d;
  logic [IDX_W-1:0]     idx_q, idx_d;
  logic [SIZE_BITS-1:0] req_q;
  logic [JOB_W-1:0]     job_cnt_q, job_q;
  logic [TOTAL_W-1:0]   total_q;
  logic [BLOCKS-1:0]    blk_busy_q;
  logic [BLOCKS-1:0]    blk_vld_q;
  logic [SIZE_BITS-1:0] sizes_mem [BLOCKS];
  logic [SIZE_BITS-1:0] rd_data_q;
  logic                 rd_vld_q;
  logic                 cmp_vld_q;
  logic [IDX_W-1:0]     cmp_idx_q;
  logic                 out_valid_q;
  wfba_out_t            out_q;

  logic                 accept, acc_load, acc_req, load_ok, last_issue;
  logic [IDX_W-1:0]     load_idx;
  logic [TOTAL_W:0]     sum;
  wfba_cmp_t            cmp;
  logic                 found;
  logic [SIZE_BITS-1:0] best_size;
  logic [IDX_W-1:0]     best_idx;

  assign accept     = start && !busy;
  assign acc_load   = accept && (in_word_i.func == FUNC_LOAD);
  assign acc_req    = accept && (in_word_i.func == FUNC_ALLOC);
  assign load_idx   = in_word_i.block_index[IDX_W-1:0];
  assign load_ok    = ({1'b0, in_word_i.block_index} < (BLK_FIELD_W + 1)'(BLOCKS));
  assign last_issue = ({1'b0, idx_q} == (limit_q - CNT_W'(1)));
  assign limit_d    = (cfg_q > CFG_W'(BLOCKS)) ? CNT_W'(BLOCKS) : CNT_W'(cfg_q);
  assign sum        = {1'b0, total_q} + (TOTAL_W + 1)'(req_q);

  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = !busy;

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    case (state_q)
      S_IDLE: begin
        if (acc_req) begin
          idx_d   = '0;
          state_d = (limit_d == '0) ? S_FINISH : S_SCAN;
        end
      end
      S_SCAN: begin
        idx_d = idx_q + IDX_W'(1);
        if (last_issue) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN:  state_d = S_FINISH;
      S_FINISH: state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cfg_q       <= CFG_W'(CfgReset);
      job_cnt_q   <= '0;
      total_q     <= '0;
      blk_busy_q  <= '0;
      blk_vld_q   <= '0;
      cmp_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cmp_vld_q   <= (state_q == S_SCAN);
      out_valid_q <= acc_load || (state_q == S_FINISH);
      if (cfg_valid_i && cfg_ready_o) begin
        cfg_q <= cfg_data_i;
      end
      if (acc_req) begin
        job_cnt_q <= job_cnt_q + JOB_W'(1);
      end
      if (acc_load && load_ok) begin
        blk_vld_q[load_idx]  <= 1'b1;
        blk_busy_q[load_idx] <= 1'b0;
      end
      if ((state_q == S_FINISH) && found) begin
        blk_busy_q[best_idx] <= 1'b1;
        total_q <= sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_load && load_ok) begin
      sizes_mem[load_idx] <= in_word_i.size_value;
    end
    rd_data_q <= sizes_mem[idx_q];
    rd_vld_q  <= blk_vld_q[idx_q];
    cmp_idx_q <= idx_q;
    idx_q     <= idx_d;
    if (acc_req) begin
      req_q   <= in_word_i.size_value;
      job_q   <= job_cnt_q;
      limit_q <= limit_d;
    end
    if (acc_load) begin
      out_q.granted      <= 1'b0;
      out_q.chosen_block <= '0;
      out_q.leftover     <= '0;
      out_q.job_id       <= '0;
      out_q.total_used   <= total_q;
    end else if (state_q == S_FINISH) begin
      out_q.granted      <= found;
      out_q.chosen_block <= found ? BLK_FIELD_W'(best_idx) : '0;
      out_q.leftover     <= found ? (best_size - req_q) : '0;
      out_q.job_id       <= job_q;
      out_q.total_used   <= !found ? total_q :
                            (sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0]);
    end
  end

  assign cmp.vld  = cmp_vld_q;
  assign cmp.busy = blk_busy_q[cmp_idx_q];
  assign cmp.idx  = cmp_idx_q;
  assign cmp.size = rd_vld_q ? rd_data_q : '0;

  wfba_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clr_i       (acc_req),
    .req_size_i  (req_q),
    .cmp_i       (cmp),
    .found_o     (found),
    .best_size_o (best_size),
    .best_idx_o  (best_idx)
  );

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  `WFBA_ASSERT_IMP(a_out_when_idle, out_valid_q, !busy, "result while busy")
  `WFBA_ASSERT_NXT(a_accept_moves, accept, busy || out_valid_q,
                   "accepted word went nowhere")
  `WFBA_ASSERT_IMP(a_grant_marks, out_valid_q && out_q.granted,
                   blk_busy_q[out_q.chosen_block[IDX_W-1:0]], "granted block not busy")
  `WFBA_ASSERT_IMP(a_grant_in_range, out_valid_q && out_q.granted,
                   {1'b0, out_q.chosen_block} < limit_q, "grant beyond blocks in use")

endmodule

>>> test/worst_fit_block_allocator_core_tb.sv
// Self-checking testbench for worst_fit_block_allocator_core, the worst-fit block allocator.
// Depends on wfba_pkg and the core RTL; words are driven from a queue and
// every result word is checked against a cycle-free predictor of the allocator.
module worst_fit_block_allocator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wfba_pkg::*;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                start       = 1'b0;
  logic                busy;
  wfba_in_t            in_word_i   = '0;
  logic                out_valid_o;
  wfba_out_t           out_word_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CFG_W-1:0]    cfg_data_i  = '0;

  worst_fit_block_allocator_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  logic [SIZE_BITS-1:0] blk_size [BLOCKS];
  logic                 blk_taken [BLOCKS];
  logic [JOB_W-1:0]     next_job;
  logic [TOTAL_W-1:0]   granted_sum;
  logic [CFG_W-1:0]     blocks_in_use;

  wfba_in_t  word_q [$];
  wfba_out_t outcome_q [$];
  wfba_out_t due;
  int        mismatches = 0;
  int        gap_left   = 0;
  logic      burst      = 1'b0;

  function automatic wfba_out_t allocate_worst_fit(input wfba_in_t w);
    wfba_out_t          r;
    int                 span;
    int                 best_i;
    logic [TOTAL_W:0]   sum;
    r = '0;
    r.total_used = granted_sum;
    if (w.func == FUNC_LOAD) begin
      blk_size[w.block_index] = w.size_value;
      blk_taken[w.block_index] = 1'b0;
      return r;
    end
    r.job_id = next_job;
    next_job = next_job + 1'b1;
    span = (blocks_in_use > BLOCKS) ? BLOCKS : int'(blocks_in_use);
    best_i = -1;
    for (int j = 0; j < span; j++) begin
      if (!blk_taken[j] && blk_size[j] >= w.size_value &&
          (best_i < 0 || blk_size[j] > blk_size[best_i]))
        best_i = j;
    end
    if (best_i < 0)
      return r;
    blk_taken[best_i] = 1'b1;
    sum = {1'b0, granted_sum} + w.size_value;
    granted_sum = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
    r.granted = 1'b1;
    r.chosen_block = best_i[BLK_FIELD_W-1:0];
    r.leftover = blk_size[best_i] - w.size_value;
    r.total_used = granted_sum;
    return r;
  endfunction

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      gap_left <= 0;
    end else if (!(start && busy)) begin
      if (start)
        outcome_q.push_back(allocate_worst_fit(in_word_i));
      if (gap_left > 0) begin
        start <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (word_q.size() != 0) begin
        in_word_i <= word_q.pop_front();
        start <= 1'b1;
        gap_left <= burst ? 0 : $urandom_range(0, 6);
        if ($urandom_range(0, 39) == 0)
          burst <= !burst;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o) begin
      if (outcome_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result word %p", $realtime, out_word_o);
      end else begin
        due = outcome_q.pop_front();
        if (due.granted !== out_word_o.granted ||
            due.chosen_block !== out_word_o.chosen_block ||
            due.leftover !== out_word_o.leftover ||
            due.job_id !== out_word_o.job_id ||
            due.total_used !== out_word_o.total_used) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: expected g=%0d blk=%0d left=%0d job=%0d tot=%0d,",
                     $realtime, due.granted, due.chosen_block, due.leftover,
                     due.job_id, due.total_used,
                     " got g=%0d blk=%0d left=%0d job=%0d tot=%0d",
                     out_word_o.granted, out_word_o.chosen_block,
                     out_word_o.leftover, out_word_o.job_id, out_word_o.total_used);
        end
      end
    end
  end

  task automatic push_word(input wfba_func_e f, input int idx, input int sz);
    wfba_in_t w;
    w.func = f;
    w.block_index = idx[BLK_FIELD_W-1:0];
    w.size_value = sz[SIZE_BITS-1:0];
    word_q.push_back(w);
  endtask

  task automatic wait_idle();
    do @(posedge clk_i);
    while (word_q.size() != 0 || start || outcome_q.size() != 0);
  endtask

  task automatic set_blocks_in_use(input int v);
    wait_idle();
    repeat (2) @(posedge clk_i);
    cfg_data_i <= v[CFG_W-1:0];
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    blocks_in_use = v[CFG_W-1:0];
    cfg_valid_i <= 1'b0;
  endtask

  function automatic int pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70)
      return $urandom_range(0, 1000);
    if (r < 85)
      return $urandom_range(0, 65535);
    if (r < 92)
      return 0;
    return 65535;
  endfunction

  task automatic random_words(input int n);
    int span;
    span = (blocks_in_use == 0 || blocks_in_use > BLOCKS) ? BLOCKS : int'(blocks_in_use);
    repeat (n) begin
      if ($urandom_range(0, 99) < 45)
        push_word(FUNC_LOAD,
                  ($urandom_range(0, 9) == 0) ? $urandom_range(0, BLOCKS - 1)
                                              : $urandom_range(0, span - 1),
                  pick_size());
      else
        push_word(FUNC_ALLOC, $urandom_range(0, BLOCKS - 1), pick_size());
    end
  endtask

  initial begin
    for (int i = 0; i < BLOCKS; i++) begin
      blk_size[i] = '0;
      blk_taken[i] = 1'b0;
    end
    next_job = '0;
    granted_sum = '0;
    blocks_in_use = CfgReset[CFG_W-1:0];
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    push_word(FUNC_ALLOC, 0, 0);
    push_word(FUNC_ALLOC, 63, 1);
    push_word(FUNC_LOAD, 63, 65535);
    push_word(FUNC_LOAD, 5, 65535);
    push_word(FUNC_ALLOC, 0, 65535);
    push_word(FUNC_ALLOC, 42, 100);
    push_word(FUNC_ALLOC, 0, 0);
    push_word(FUNC_LOAD, 5, 300);
    push_word(FUNC_ALLOC, 0, 200);
    push_word(FUNC_LOAD, 0, 16'h5555);
    push_word(FUNC_LOAD, 42, 16'hAAAA);
    push_word(FUNC_LOAD, 21, 16'hAAAA);
    push_word(FUNC_ALLOC, 21, 16'h5555);
    push_word(FUNC_ALLOC, 0, 16'hAAAA);
    push_word(FUNC_ALLOC, 0, 16'h5555);
    push_word(FUNC_ALLOC, 0, 16'hFFFF);
    push_word(FUNC_LOAD, 63, 0);
    push_word(FUNC_ALLOC, 0, 0);

    set_blocks_in_use(0);
    random_words(12);

    // Single block in use: repeated full-size grants drive the total into saturation.
    set_blocks_in_use(1);
    repeat (260) begin
      push_word(FUNC_LOAD, 0, 65535);
      push_word(FUNC_ALLOC, $urandom_range(0, BLOCKS - 1), 65535);
    end
    push_word(FUNC_LOAD, 0, 65535);
    push_word(FUNC_ALLOC, 0, 0);

    set_blocks_in_use(127);
    random_words(150);
    set_blocks_in_use(64);
    random_words(150);
    set_blocks_in_use($urandom_range(2, 63));
    random_words(150);
    set_blocks_in_use(3);
    random_words(100);

    wait_idle();
    repeat (80) @(posedge clk_i);
    if (mismatches == 0 && outcome_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
